// ===== hw/rtl/spq_pkg.sv =====
// shared constants, types and codes for the scan priority queue
package spq_pkg;

  localparam int QUEUE_DEPTH      = 64;
  localparam int PRIORITY_ENTRIES = 256;
  localparam int ITEM_W           = 8;
  localparam int PRIO_W           = 32;
  localparam int REQ_W            = 3;
  localparam int STATUS_W         = 2;
  localparam int QCOUNT_W         = 7;
  localparam int QA_W             = $clog2(QUEUE_DEPTH);
  localparam int CNT_W            = $clog2(QUEUE_DEPTH + 1);
  localparam int PT_AW            = $clog2(PRIORITY_ENTRIES);
  localparam int KEY_W            = (ITEM_W > QA_W) ? ITEM_W : QA_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD        = 3'd0,
    REQ_PULL_HI    = 3'd1,
    REQ_PULL_LO    = 3'd2,
    REQ_WRITE_PRIO = 3'd3,
    REQ_SHRINK_HI  = 3'd4,
    REQ_SHRINK_LO  = 3'd5
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_COPY,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [ITEM_W-1:0]        item_value;
    logic signed [PRIO_W-1:0] priority_value;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ITEM_W-1:0]   out_value;
    logic [QCOUNT_W-1:0] queue_count;
  } out_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic scan_start;
    logic shift_start;
    logic commit;
    logic copy_start;
    logic res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_pull;
    logic is_shrink;
    logic empty;
    logic keep_ge;
    logic scan_done;
    logic shift_done;
    logic copy_done;
    logic last_keep;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== hw/rtl/spq_dp.sv =====
// datapath: queue and priority memories, scan pipeline, gap close, shrink copy, result register
module spq_dp
  import spq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  in_t      in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_t     out_data_o,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o
);

  logic                     mode_q;
  logic [REQ_W-1:0]         req_q;
  logic [ITEM_W-1:0]        val_q;
  logic signed [PRIO_W-1:0] prio_q;
  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         keep_q;
  logic [QA_W-1:0]          kidx_q;
  logic [STATUS_W-1:0]      res_status_q;
  logic [ITEM_W-1:0]        res_val_q;
  logic                     out_valid_q;
  out_t                     out_q;

  logic [ITEM_W-1:0] q_mem    [QUEUE_DEPTH];
  logic [ITEM_W-1:0] kept_mem [QUEUE_DEPTH];
  logic signed [PRIO_W-1:0] pt_mem [PRIORITY_ENTRIES];
  logic [PRIORITY_ENTRIES-1:0] pt_vld_q;

  logic [QA_W-1:0]   q_raddr;
  logic [ITEM_W-1:0] q_rdata_q;
  logic              q_we;
  logic [QA_W-1:0]   q_waddr;
  logic [ITEM_W-1:0] q_wdata;
  logic [ITEM_W-1:0] kept_rdata_q;

  logic [QA_W-1:0]          rd_idx_q;
  logic                     rd_iss_q;
  logic                     s1_v_q;
  logic [QA_W-1:0]          s1_pos_q;
  logic                     s2_v_q;
  logic [QA_W-1:0]          s2_pos_q;
  logic [ITEM_W-1:0]        s2_val_q;
  logic                     s2_inr_q;
  logic [QA_W-1:0]          best_pos_q;
  logic signed [PRIO_W-1:0] best_prio_q;
  logic [ITEM_W-1:0]        best_val_q;
  logic signed [PRIO_W-1:0] pt_rdata_q;
  logic                     pt_vld_rd_q;

  logic [QA_W-1:0] sh_idx_q;
  logic            sh_iss_q;
  logic            sh_v_q;
  logic [QA_W-1:0] sh_wa_q;
  logic [QA_W-1:0] cp_idx_q;
  logic            cp_iss_q;
  logic            cp_v_q;
  logic [QA_W-1:0] cp_wa_q;

  logic                     is_add, is_pull, is_wr, is_shrink, want_high;
  logic                     full, empty;
  logic [CNT_W:0]           keep_sum;
  logic [CNT_W-1:0]         keep_calc;
  logic [KEY_W-1:0]         key;
  logic                     key_inr;
  logic [PT_AW-1:0]         pt_raddr;
  logic [PT_AW-1:0]         pt_waddr;
  logic                     pt_we;
  logic signed [PRIO_W-1:0] cur_prio;
  logic                     better, take;
  logic                     add_ok;

  // request decode
  assign is_add    = (req_q == REQ_ADD);
  assign is_pull   = (req_q == REQ_PULL_HI) || (req_q == REQ_PULL_LO);
  assign is_wr     = (req_q == REQ_WRITE_PRIO);
  assign is_shrink = (req_q == REQ_SHRINK_HI) || (req_q == REQ_SHRINK_LO);
  assign want_high = (req_q == REQ_PULL_HI) || (req_q == REQ_SHRINK_HI);

  assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_q == '0);
  assign keep_sum  = {1'b0, count_q} + (CNT_W+1)'(2);
  assign keep_calc = keep_sum[CNT_W:1];
  assign add_ok    = cmd_i.decode && is_add && !full;

  // priority lookup key
  assign key      = mode_q ? KEY_W'(s1_pos_q) : KEY_W'(q_rdata_q);
  assign key_inr  = (32'(key) < PRIORITY_ENTRIES);
  assign pt_raddr = PT_AW'(key);
  assign pt_waddr = PT_AW'(val_q);
  assign pt_we    = cmd_i.decode && is_wr && (32'(val_q) < PRIORITY_ENTRIES);

  // compare stage
  assign cur_prio = (pt_vld_rd_q && s2_inr_q) ? pt_rdata_q : '0;
  assign better   = want_high ? (cur_prio > best_prio_q) : (cur_prio < best_prio_q);
  assign take     = s2_v_q && ((s2_pos_q == '0) || better);

  // queue memory ports
  assign q_raddr = rd_iss_q ? rd_idx_q : (sh_idx_q + QA_W'(1));

  always_comb begin
    q_we    = 1'b0;
    q_waddr = cp_wa_q;
    q_wdata = kept_rdata_q;
    if (add_ok) begin
      q_we    = 1'b1;
      q_waddr = QA_W'(count_q);
      q_wdata = val_q;
    end else if (sh_v_q) begin
      q_we    = 1'b1;
      q_waddr = sh_wa_q;
      q_wdata = q_rdata_q;
    end else if (cp_v_q) begin
      q_we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rdata_q <= q_mem[q_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && is_shrink) begin
      kept_mem[kidx_q] <= best_val_q;
    end
    kept_rdata_q <= kept_mem[cp_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= prio_q;
    end
    pt_rdata_q  <= pt_mem[pt_raddr];
    pt_vld_rd_q <= pt_vld_q[pt_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      count_q     <= '0;
      kidx_q      <= '0;
      rd_idx_q    <= '0;
      rd_iss_q    <= 1'b0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      sh_idx_q    <= '0;
      sh_iss_q    <= 1'b0;
      sh_v_q      <= 1'b0;
      cp_idx_q    <= '0;
      cp_iss_q    <= 1'b0;
      cp_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pt_vld_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end

      if (cmd_i.copy_start) begin
        count_q <= keep_q;
      end else if (cmd_i.commit) begin
        count_q <= count_q - CNT_W'(1);
      end else if (add_ok) begin
        count_q <= count_q + CNT_W'(1);
      end

      if (cmd_i.decode) begin
        kidx_q <= '0;
      end else if (cmd_i.commit && is_shrink) begin
        kidx_q <= kidx_q + QA_W'(1);
      end

      if (pt_we) begin
        pt_vld_q[pt_waddr] <= 1'b1;
      end

      // scan issue
      if (cmd_i.scan_start) begin
        rd_idx_q <= '0;
        rd_iss_q <= 1'b1;
      end else if (rd_iss_q) begin
        rd_idx_q <= rd_idx_q + QA_W'(1);
        if (CNT_W'(rd_idx_q) == count_q - CNT_W'(1)) begin
          rd_iss_q <= 1'b0;
        end
      end
      s1_v_q <= rd_iss_q;
      s2_v_q <= s1_v_q;

      // gap close
      if (cmd_i.shift_start) begin
        sh_idx_q <= best_pos_q;
        sh_iss_q <= (CNT_W'(best_pos_q) + CNT_W'(1) < count_q);
      end else if (sh_iss_q) begin
        sh_idx_q <= sh_idx_q + QA_W'(1);
        sh_iss_q <= (CNT_W'(sh_idx_q) + CNT_W'(2) < count_q);
      end
      sh_v_q <= sh_iss_q;

      // shrink copy back
      if (cmd_i.copy_start) begin
        cp_idx_q <= '0;
        cp_iss_q <= 1'b1;
      end else if (cp_iss_q) begin
        cp_idx_q <= cp_idx_q + QA_W'(1);
        cp_iss_q <= (CNT_W'(cp_idx_q) + CNT_W'(1) < keep_q);
      end
      cp_v_q <= cp_iss_q;

      out_valid_q <= cmd_i.res_load || (out_valid_q && out_stall_i);
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= in_data_i.req_type;
      val_q  <= in_data_i.item_value;
      prio_q <= in_data_i.priority_value;
    end
    if (cmd_i.decode) begin
      keep_q    <= keep_calc;
      res_val_q <= '0;
      if (is_add && full) begin
        res_status_q <= STAT_FULL;
      end else if (is_pull && empty) begin
        res_status_q <= STAT_EMPTY;
      end else begin
        res_status_q <= STAT_DONE;
      end
    end
    if (cmd_i.commit && !is_shrink) begin
      res_val_q <= best_val_q;
    end
    s1_pos_q <= rd_idx_q;
    s2_pos_q <= s1_pos_q;
    s2_val_q <= q_rdata_q;
    s2_inr_q <= key_inr;
    if (take) begin
      best_pos_q  <= s2_pos_q;
      best_prio_q <= cur_prio;
      best_val_q  <= s2_val_q;
    end
    sh_wa_q <= sh_idx_q;
    cp_wa_q <= cp_idx_q;
    if (cmd_i.res_load) begin
      out_q.status      <= res_status_q;
      out_q.out_value   <= res_val_q;
      out_q.queue_count <= QCOUNT_W'(count_q);
    end
  end

  assign stat_o.is_pull    = is_pull;
  assign stat_o.is_shrink  = is_shrink;
  assign stat_o.empty      = empty;
  assign stat_o.keep_ge    = (keep_calc >= count_q);
  assign stat_o.scan_done  = !rd_iss_q && !s1_v_q && !s2_v_q;
  assign stat_o.shift_done = !sh_iss_q && !sh_v_q;
  assign stat_o.copy_done  = !cp_iss_q && !cp_v_q;
  assign stat_o.last_keep  = (CNT_W'(kidx_q) + CNT_W'(1) == keep_q);
  assign stat_o.out_busy   = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("item count beyond queue depth");

  a_one_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({rd_iss_q, sh_iss_q, cp_iss_q}))
    else $error("scan, gap close and copy overlap");

  a_commit_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && !cmd_i.copy_start |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("pull did not remove one item");

  a_res_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |=> out_valid_q)
    else $error("result not presented");

endmodule

// ===== hw/rtl/spq_ctrl.sv =====
// controller state machine sequencing decode, scan, gap close, copy and result
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   need_scan;

  assign need_scan = (stat_i.is_pull && !stat_i.empty) ||
                     (stat_i.is_shrink && !stat_i.keep_ge);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        state_d = need_scan ? S_SCAN : S_FIN;
      end
      S_SCAN: begin
        if (stat_i.scan_done) state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if (stat_i.shift_done) begin
          if (!stat_i.is_shrink) begin
            state_d = S_FIN;
          end else if (stat_i.last_keep) begin
            state_d = S_COPY;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_COPY: begin
        if (stat_i.copy_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (!stat_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_DECODE: begin
        cmd_o.decode     = 1'b1;
        cmd_o.scan_start = need_scan;
      end
      S_SCAN: begin
        cmd_o.shift_start = stat_i.scan_done;
      end
      S_SHIFT: begin
        if (stat_i.shift_done) begin
          cmd_o.commit     = 1'b1;
          cmd_o.copy_start = stat_i.is_shrink && stat_i.last_keep;
          cmd_o.scan_start = stat_i.is_shrink && !stat_i.last_keep;
        end
      end
      S_COPY: begin
      end
      S_FIN: begin
        cmd_o.res_load = !stat_i.out_busy;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/scan_priority_queue.sv =====
// top level of the scan priority queue
//
//   channel  signals                          payload
//   in       in_valid_i / in_stall_o          in_data_i  (req_type, item_value, priority_value)
//   out      out_valid_o / out_stall_i        out_data_o (status, out_value, queue_count)
//   cfg      cfg_we_i                         cfg_wdata_i (mapping_mode)
//
// one transaction at a time; add, priority write and no-op skip the scan and go from decode to the result
// a pull over n items: a scan through the queue and priority table read ports,
// then a gap close on the queue write port
// a shrink repeats the pull k = (n+2)/2 times unless k >= n, then copies k items back
// reset clears the count, mode and the priority valid bits at once; no clearing pass
// a new transaction is taken while the previous result waits behind out_stall_i
module scan_priority_queue
  import spq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  spq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
